@@ src/mwm_pkg.sv @@
// Package for the mecanum wheel speed mixer: payload structs, CORDIC constants.
// No dependencies.
`default_nettype none
package mwm_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] strafe_cmd;
    logic signed [15:0] forward_cmd;
    logic signed [15:0] turn_cmd;
    logic        [15:0] heading;
    logic               strafe_flip;
  } mwm_in_t;

  typedef struct packed {
    logic signed [15:0] front_left_drive;
    logic signed [15:0] front_right_drive;
    logic signed [15:0] rear_left_drive;
    logic signed [15:0] rear_right_drive;
  } mwm_out_t;

  // Configuration register indexes
  localparam logic CFG_DRIVE_MODE = 1'b0;
  localparam logic CFG_INVERT     = 1'b1;

  // Classified item handed from front to back
  typedef struct packed {
    logic               tank;
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [15:0] r;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] z;
    logic               neg;
  } mwm_item_t;

  function automatic logic signed [33:0] atan_turn(input int i);
    unique case (i)
      0: atan_turn = 34'sd536870912;   1: atan_turn = 34'sd316933406;
      2: atan_turn = 34'sd167458907;   3: atan_turn = 34'sd85004756;
      4: atan_turn = 34'sd42667331;    5: atan_turn = 34'sd21354465;
      6: atan_turn = 34'sd10679838;    7: atan_turn = 34'sd5340245;
      8: atan_turn = 34'sd2670163;     9: atan_turn = 34'sd1335087;
      10: atan_turn = 34'sd667544;     11: atan_turn = 34'sd333772;
      12: atan_turn = 34'sd166886;     13: atan_turn = 34'sd83443;
      14: atan_turn = 34'sd41722;      15: atan_turn = 34'sd20861;
      16: atan_turn = 34'sd10430;      17: atan_turn = 34'sd5215;
      18: atan_turn = 34'sd2608;       19: atan_turn = 34'sd1304;
      20: atan_turn = 34'sd652;        21: atan_turn = 34'sd326;
      22: atan_turn = 34'sd163;        23: atan_turn = 34'sd81;
      24: atan_turn = 34'sd41;         25: atan_turn = 34'sd20;
      26: atan_turn = 34'sd10;         27: atan_turn = 34'sd5;
      default: atan_turn = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ src/mwm_front.sv @@
// Front end: signs the commands by mode and reduces the heading for CORDIC.
// Depends on mwm_pkg.
`default_nettype none
module mwm_front #(
  parameter int ANGLE_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  mwm_pkg::mwm_in_t    in_data,
  input  wire                 drive_mode,
  input  wire                 invert_controls,
  output logic                item_valid,
  output mwm_pkg::mwm_item_t  item
);
  import mwm_pkg::*;

  logic               item_valid_r;
  mwm_item_t          item_r;
  mwm_item_t          item_nxt;
  logic        [31:0] ang;
  logic        [31:0] ang_red;
  logic               neg;
  logic               flip_x;
  logic               flip_y;

  // Classify the command and reduce the angle to the right half-plane
  always_comb begin
    ang = 32'(in_data.heading) << (32 - ANGLE_BITS);
    neg = ang[31] ^ ang[30];
    ang_red = neg ? ang - 32'h8000_0000 : ang;
    flip_x = 1'b1 ^ in_data.strafe_flip ^ invert_controls;
    flip_y = 1'b1 ^ invert_controls;
    item_nxt.tank = drive_mode;
    if (drive_mode) begin
      item_nxt.x = 17'(in_data.strafe_cmd);
      item_nxt.y = 17'(in_data.forward_cmd);
    end else begin
      item_nxt.x = flip_x ? -17'(in_data.strafe_cmd) : 17'(in_data.strafe_cmd);
      item_nxt.y = flip_y ? -17'(in_data.forward_cmd) : 17'(in_data.forward_cmd);
    end
    item_nxt.r = in_data.turn_cmd;
    item_nxt.cx = CORDIC_GAIN;
    item_nxt.cy = '0;
    item_nxt.z = 34'(signed'(ang_red));
    item_nxt.neg = neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= in_valid;
    end
    item_r <= item_nxt;
  end

  assign item_valid = item_valid_r;
  assign item = item_r;
endmodule
`default_nettype wire

@@ src/mwm_cordic.sv @@
// Pipelined CORDIC rotator, one stage per iteration, item rides alongside.
// Depends on mwm_pkg.
`default_nettype none
module mwm_cordic (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  mwm_pkg::mwm_item_t  in_item,
  output logic                out_valid,
  output mwm_pkg::mwm_item_t  out_item
);
  import mwm_pkg::*;

  logic      [CORDIC_STEPS:0] valid_r;
  mwm_item_t                  stage_r [CORDIC_STEPS+1];

  always_comb begin
    valid_r[0] = in_valid;
    stage_r[0] = in_item;
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    mwm_item_t st_nxt;
    always_comb begin
      st_nxt = stage_r[i];
      if (!stage_r[i].z[33]) begin
        st_nxt.cx = stage_r[i].cx - (stage_r[i].cy >>> i);
        st_nxt.cy = stage_r[i].cy + (stage_r[i].cx >>> i);
        st_nxt.z  = stage_r[i].z - atan_turn(i);
      end else begin
        st_nxt.cx = stage_r[i].cx + (stage_r[i].cy >>> i);
        st_nxt.cy = stage_r[i].cy - (stage_r[i].cx >>> i);
        st_nxt.z  = stage_r[i].z + atan_turn(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else begin
        valid_r[i+1] <= valid_r[i];
      end
      stage_r[i+1] <= st_nxt;
    end
  end

  assign out_valid = valid_r[CORDIC_STEPS];
  assign out_item = stage_r[CORDIC_STEPS];
endmodule
`default_nettype wire

@@ src/mwm_divider.sv @@
// Pipelined restoring divider: quotient bits one stage each, numerator < 2^QB * den.
// Stand-alone; carries a sign alongside.
`default_nettype none
module mwm_divider #(
  parameter int NW = 40,
  parameter int DW = 20,
  parameter int QB = 16
) (
  input  wire                 clk,
  input  wire  [NW-1:0]       num,
  input  wire  [DW-1:0]       den,
  input  wire                 neg_in,
  output logic [QB-1:0]       quo,
  output logic                neg_out
);
  logic [DW:0]    rem_r  [QB+1];
  logic [NW-1:0]  num_r  [QB+1];
  logic [DW-1:0]  den_r  [QB+1];
  logic [QB-1:0]  q_r    [QB+1];
  logic           neg_r  [QB+1];

  // Start from the numerator's upper bits, already below the divisor
  always_comb begin
    rem_r[0] = (DW+1)'(num >> QB);
    num_r[0] = num;
    den_r[0] = den;
    q_r[0] = '0;
    neg_r[0] = neg_in;
  end

  // Shift in one numerator bit a stage and resolve one quotient bit
  for (genvar i = 0; i < QB; i++) begin : g_bit
    logic [DW:0] sh;
    logic        take;
    always_comb begin
      sh = {rem_r[i][DW-1:0], num_r[i][QB-1-i]};
      take = sh >= {1'b0, den_r[i]};
    end
    always_ff @(posedge clk) begin
      rem_r[i+1] <= take ? sh - {1'b0, den_r[i]} : sh;
      q_r[i+1] <= take ? (q_r[i] | (QB'(1) << (QB-1-i))) : q_r[i];
      num_r[i+1] <= num_r[i];
      den_r[i+1] <= den_r[i];
      neg_r[i+1] <= neg_r[i];
    end
  end

  assign quo = q_r[QB];
  assign neg_out = neg_r[QB];
endmodule
`default_nettype wire

@@ src/mwm_back.sv @@
// Back end: rotation, wheel mix, normalisation and output saturation.
// Depends on mwm_pkg and mwm_divider.
`default_nettype none
module mwm_back #(
  parameter int FRAC_BITS = 14
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  mwm_pkg::mwm_item_t  in_item,
  output logic                out_valid,
  output mwm_pkg::mwm_out_t   out_data
);
  import mwm_pkg::*;

  localparam int WW = 20;
  localparam int NW = WW + FRAC_BITS + 1;
  localparam int QB = FRAC_BITS + 2;
  localparam int LAT = QB;
  localparam logic [WW:0] ONE = (WW+1)'(1) << FRAC_BITS;

  // Stage 1: products
  logic               v1_r;
  logic               tank1_r;
  logic signed [16:0] x1_r, y1_r;
  logic signed [15:0] r1_r;
  logic signed [50:0] xc_r, ys_r, xs_r, yc_r;
  logic signed [33:0] c_s, s_s;

  always_comb begin
    c_s = in_item.neg ? -in_item.cx : in_item.cx;
    s_s = in_item.neg ? -in_item.cy : in_item.cy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    tank1_r <= in_item.tank;
    x1_r <= in_item.x;
    y1_r <= in_item.y;
    r1_r <= in_item.r;
    xc_r <= 51'(in_item.x) * 51'(c_s);
    ys_r <= 51'(in_item.y) * 51'(s_s);
    xs_r <= 51'(in_item.x) * 51'(s_s);
    yc_r <= 51'(in_item.y) * 51'(c_s);
  end

  // Stage 2: rotate and mix into wheels
  logic                    v2_r;
  logic signed [WW-1:0]    w_r [4];
  logic signed [51:0]      xr_full, yr_full;
  logic signed [WW-1:0]    xr, yr, xa, ya, ra;

  always_comb begin
    xr_full = (52'(xc_r) - 52'(ys_r) + 52'sd536870912) >>> 30;
    yr_full = (52'(xs_r) + 52'(yc_r) + 52'sd536870912) >>> 30;
    xr = tank1_r ? WW'(x1_r) : WW'(xr_full);
    yr = tank1_r ? WW'(y1_r) : WW'(yr_full);
    xa = WW'(x1_r);
    ya = WW'(y1_r);
    ra = WW'(r1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    w_r[0] <= xr + yr + ra;
    w_r[1] <= -xr + yr - ra;
    w_r[2] <= tank1_r ? (xa + ya + ra) : (-xr + yr + ra);
    w_r[3] <= tank1_r ? (-xa + ya - ra) : (xr + yr - ra);
  end

  // Stage 3: magnitudes and maximum
  logic                 v3_r;
  logic [WW-1:0]        mag_r [4];
  logic                 sgn_r [4];
  logic signed [WW-1:0] w3_r [4];
  logic [WW-1:0]        mag [4];
  logic [WW-1:0]        mx01, mx23;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = w_r[i][WW-1] ? WW'(-w_r[i]) : WW'(w_r[i]);
    end
  end

  logic [WW-1:0] mx01_r, mx23_r;
  always_comb begin
    mx01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
    mx23 = (mag[3] > mag[2]) ? mag[3] : mag[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    for (int i = 0; i < 4; i++) begin
      mag_r[i] <= mag[i];
      sgn_r[i] <= w_r[i][WW-1];
      w3_r[i] <= w_r[i];
    end
    mx01_r <= mx01;
    mx23_r <= mx23;
  end

  // Stage 4: scale decision and numerators
  logic                 v4_r;
  logic                 scale4_r;
  logic [NW-1:0]        num4_r [4];
  logic [WW-1:0]        mx4_r;
  logic                 sgn4_r [4];
  logic signed [WW-1:0] w4_r [4];
  logic [WW-1:0]        mx;

  assign mx = (mx23_r > mx01_r) ? mx23_r : mx01_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    scale4_r <= mx > ONE;
    mx4_r <= mx;
    for (int i = 0; i < 4; i++) begin
      num4_r[i] <= (NW'(mag_r[i]) << FRAC_BITS) + NW'(mx >> 1);
      sgn4_r[i] <= sgn_r[i];
      w4_r[i] <= w3_r[i];
    end
  end

  // Dividers, one per wheel
  logic [QB-1:0] quo [4];
  logic          qneg [4];
  for (genvar g = 0; g < 4; g++) begin : g_div
    mwm_divider #(.NW(NW), .DW(WW), .QB(QB)) u_div (
      .clk    (clk),
      .num    (num4_r[g]),
      .den    (mx4_r),
      .neg_in (sgn4_r[g]),
      .quo    (quo[g]),
      .neg_out(qneg[g])
    );
  end

  // Delay the bypass path alongside the divider
  logic [LAT:0]         vd_r;
  logic                 sc_d_r [LAT+1];
  logic signed [WW-1:0] wd_r [LAT+1][4];

  always_comb begin
    vd_r[0] = v4_r;
    sc_d_r[0] = scale4_r;
    wd_r[0] = w4_r;
  end

  for (genvar k = 0; k < LAT; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k+1] <= 1'b0;
      end else begin
        vd_r[k+1] <= vd_r[k];
      end
      sc_d_r[k+1] <= sc_d_r[k];
      wd_r[k+1] <= wd_r[k];
    end
  end

  // Final: pick scaled or raw, negate right side, saturate
  function automatic logic signed [15:0] sat16(input logic signed [WW+1:0] v);
    if (v > 32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -32768) begin
      sat16 = -16'sh8000;
    end else begin
      sat16 = 16'(v);
    end
  endfunction

  logic signed [WW+1:0] fw [4];
  mwm_out_t             out_nxt;
  mwm_out_t             out_r;
  logic                 out_valid_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (sc_d_r[LAT]) begin
        fw[i] = qneg[i] ? -(WW+2)'(quo[i]) : (WW+2)'(quo[i]);
      end else begin
        fw[i] = (WW+2)'(wd_r[LAT][i]);
      end
    end
    out_nxt.front_left_drive  = sat16(fw[0]);
    out_nxt.front_right_drive = sat16(-fw[1]);
    out_nxt.rear_left_drive   = sat16(fw[2]);
    out_nxt.rear_right_drive  = sat16(-fw[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vd_r[LAT];
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;
endmodule
`default_nettype wire

@@ src/mecanum_wheel_speed_mixer.sv @@
// Top level of the mecanum wheel speed mixer: config registers, front, CORDIC, back.
// Depends on mwm_pkg, mwm_front, mwm_cordic, mwm_back.
//
//  channel | ports                              | flow
//  input   | start, busy, in_data               | start & !busy
//  result  | out_strobe, out_data               | one cycle, no stall
//  config  | cfg_we, cfg_index, cfg_data        | write on we
//
// One command accepted per cycle; the path runs through 1 front register, 28 CORDIC stages,
// 4 mix/normalise stages, FRAC_BITS+2 divider stages and 1 output register.
// busy is never raised: the pipeline has no stall point.
// Reset clears the valid chain and the configuration registers.
`default_nettype none
module mecanum_wheel_speed_mixer #(
  parameter int FRAC_BITS  = 14,
  parameter int ANGLE_BITS = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  mwm_pkg::mwm_in_t   in_data,
  output logic               out_strobe,
  output mwm_pkg::mwm_out_t  out_data,
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire                cfg_data
);
  import mwm_pkg::*;

  logic      drive_mode_r;
  logic      invert_r;
  logic      f_valid, c_valid;
  mwm_item_t f_item, c_item;

  assign busy = 1'b0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_mode_r <= 1'b0;
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DRIVE_MODE: drive_mode_r <= cfg_data;
        CFG_INVERT:     invert_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mwm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start & ~busy), .in_data(in_data),
    .drive_mode(drive_mode_r), .invert_controls(invert_r),
    .item_valid(f_valid), .item(f_item)
  );

  mwm_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_item(f_item),
    .out_valid(c_valid), .out_item(c_item)
  );

  mwm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(c_valid), .in_item(c_item),
    .out_valid(out_strobe), .out_data(out_data)
  );

`ifndef NO_ASSERTIONS
  // A transfer must reach the CORDIC in the cycle after acceptance
  a_front_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> f_valid) else $error("front lost a transfer");
  // The front left output stays within one full scale magnitude
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.front_left_drive <= 16'sd16384 &&
                    out_data.front_left_drive >= -16'sd16384))
    else $error("wheel drive out of range");
`endif
endmodule
`default_nettype wire
